[rtl/sgb_cpp_pkg.sv]
// sgb_cpp_pkg: shared constants, codes and control/status structs of the
// command packet processor; no dependencies
`timescale 1ns / 1ps
package sgb_cpp_pkg;

   localparam int MAP_COLUMNS  = 20;
   localparam int MAP_ROWS     = 18;
   localparam int MAX_PACKETS  = 7;
   localparam int PACKET_BYTES = 16;

   localparam int BUF_DEPTH = MAX_PACKETS * PACKET_BYTES;
   localparam int MAP_CELLS = MAP_COLUMNS * MAP_ROWS;
   localparam int BUF_AW    = 7;
   localparam int X_W       = 5;
   localparam int Y_W       = 5;
   localparam int CELL_W    = 9;
   localparam int PAL_N     = 16;

   localparam logic [X_W-1:0] COL_LAST = X_W'(MAP_COLUMNS - 1);
   localparam logic [Y_W-1:0] ROW_LAST = Y_W'(MAP_ROWS - 1);

   // request command codes
   localparam logic [1:0] CMD_PUSH      = 2'd0;
   localparam logic [1:0] CMD_READ_ATTR = 2'd1;
   localparam logic [1:0] CMD_READ_PAL  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_STORED   = 2'd0;
   localparam logic [1:0] ST_EXECUTED = 2'd1;
   localparam logic [1:0] ST_READBACK = 2'd2;

   // opcodes
   localparam logic [4:0] OP_ATTR_BLK = 5'h04;
   localparam logic [4:0] OP_ATTR_DIV = 5'h06;
   localparam logic [4:0] OP_ATTR_CHR = 5'h07;
   localparam logic [4:0] OP_MLT_REQ  = 5'h11;
   localparam logic [4:0] OP_MASK_EN  = 5'h17;

   // packet buffer fetch sources
   localparam logic [1:0] SRC_HDR = 2'd0;
   localparam logic [1:0] SRC_GRP = 2'd1;
   localparam logic [1:0] SRC_CHR = 2'd2;

   // attribute map sweep modes
   localparam logic [1:0] SWP_CLEAR = 2'd0;
   localparam logic [1:0] SWP_BLK   = 2'd1;
   localparam logic [1:0] SWP_DIV   = 2'd2;

   localparam logic [3:0] PAL_TARGETS [4][6] = '{
      '{4'd1, 4'd2,  4'd3,  4'd5,  4'd6,  4'd7},
      '{4'd9, 4'd10, 4'd11, 4'd13, 4'd14, 4'd15},
      '{4'd1, 4'd2,  4'd3,  4'd13, 4'd14, 4'd15},
      '{4'd5, 4'd6,  4'd7,  4'd9,  4'd10, 4'd11}
   };

   typedef struct packed {
      logic       accept;
      logic       rd_capture;
      logic       fetch_start;
      logic [1:0] fetch_src;
      logic       dispatch;
      logic       sweep;
      logic [1:0] sweep_mode;
      logic       chr_write;
      logic       finish;
   } sgb_cpp_cmd_type;

   typedef struct packed {
      logic push_exec;
      logic fetch_done;
      logic sweep_last;
      logic is_blk;
      logic is_div;
      logic is_chr;
      logic grp_end;
      logic blk_bad;
      logic chr_stop;
   } sgb_cpp_stat_type;

endpackage

[rtl/sgb_cpp_req_if.sv]
// sgb_cpp_req_if: request channel (valid/ready plus request payload)
// depends on nothing
`timescale 1ns / 1ps
interface sgb_cpp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data_byte;
   logic [8:0] read_index;

   modport source (output valid, command, data_byte, read_index, input ready);
   modport sink (input valid, command, data_byte, read_index, output ready);
endinterface

[rtl/sgb_cpp_rsp_if.sv]
// sgb_cpp_rsp_if: result channel (valid/ready plus result payload)
// depends on nothing
`timescale 1ns / 1ps
interface sgb_cpp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [14:0] read_value;
   logic [4:0]  executed_opcode;
   logic        freeze_active;
   logic [7:0]  freeze_mode;
   logic        multiplayer_on;
   logic [8:0]  player_count;

   modport source (output valid, status, read_value, executed_opcode, freeze_active,
                   freeze_mode, multiplayer_on, player_count, input ready);
   modport sink (input valid, status, read_value, executed_opcode, freeze_active,
                 freeze_mode, multiplayer_on, player_count, output ready);
endinterface

[rtl/sgb_cpp_datapath.sv]
// sgb_cpp_datapath: packet buffer, attribute map, palette, mode registers,
// fetch/sweep counters and result register; uses sgb_cpp_pkg
`timescale 1ns / 1ps
module sgb_cpp_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  sgb_cpp_pkg::sgb_cpp_cmd_type  cmd,
   output sgb_cpp_pkg::sgb_cpp_stat_type stat,
   input  logic [1:0]                    req_command,
   input  logic [7:0]                    req_data_byte,
   input  logic [8:0]                    req_read_index,
   output logic [1:0]                    rsp_status,
   output logic [14:0]                   rsp_read_value,
   output logic [4:0]                    rsp_executed_opcode,
   output logic                          rsp_freeze_active,
   output logic [7:0]                    rsp_freeze_mode,
   output logic                          rsp_multiplayer_on,
   output logic [8:0]                    rsp_player_count
);
   import sgb_cpp_pkg::*;

   logic [7:0]        buf_mem [BUF_DEPTH];
   logic [1:0]        attr_mem [MAP_CELLS];
   logic [7:0]        buf_q_ff;
   logic [1:0]        attr_q_ff;

   logic [BUF_AW-1:0] byte_cnt_ff, byte_cnt_in;
   logic [2:0]        exp_ff, exp_in;
   logic [4:0]        op_ff, op_in;
   logic [14:0]       pal_ff [PAL_N];
   logic              freeze_ff;
   logic [7:0]        fmode_ff;
   logic              multi_ff;
   logic [8:0]        players_ff;

   logic [7:0]        hdr_ff [5];
   logic [7:0]        grp_ff [6];
   logic [7:0]        chr_byte_ff;
   logic [7:0]        low_ff;

   logic [7:0]        fa_ff;
   logic [3:0]        fcnt_ff;
   logic              fvld_ff;
   logic [3:0]        rx_ff;
   logic [1:0]        src_ff;

   logic [X_W-1:0]    x_ff;
   logic [Y_W-1:0]    y_ff;
   logic [CELL_W-1:0] cell_ff;
   logic [4:0]        g_ff;
   logic [7:0]        b_ff;
   logic [8:0]        k_ff;
   logic              chr_end_ff;

   logic [1:0]        pend_status_ff;
   logic [14:0]       pend_value_ff;
   logic [4:0]        pend_op_ff;
   logic              rd_ok_ff;

   logic [6:0]        total;
   logic [6:0]        tot_in;
   logic [7:0]        cnt_inc;
   logic              push_exec;

   logic [X_W-1:0]    blk_xl, blk_xr, blk_xr_raw;
   logic [Y_W-1:0]    blk_yt, blk_yb, blk_yb_raw;
   logic [2:0]        blk_ctrl;
   logic [7:0]        blk_pc;
   logic              in_rect, on_border;

   logic [7:0]        div_ctl;
   logic [4:0]        div_line_raw, div_line, div_pos;

   logic [X_W-1:0]    chr_xl;
   logic [Y_W-1:0]    chr_yt;
   logic [8:0]        chr_count;
   logic [7:0]        chr_bi;
   logic [1:0]        chr_val;
   logic [CELL_W-1:0] chr_addr;

   logic              map_we;
   logic [CELL_W-1:0] map_addr;
   logic [1:0]        map_val;
   logic              sweep_last;
   logic [2:0]        pal_c;

   // accept-time packet bookkeeping
   always_comb begin
      exp_in = exp_ff;
      op_in  = op_ff;
      if (byte_cnt_ff == '0) begin
         exp_in = req_data_byte[2:0];
         if (exp_in == 3'd0) exp_in = 3'd1;
         if (exp_in > 3'(MAX_PACKETS)) exp_in = 3'(MAX_PACKETS);
         op_in = req_data_byte[7:3];
      end
      tot_in      = {exp_in, 4'b0000};
      cnt_inc     = {1'b0, byte_cnt_ff} + 8'd1;
      push_exec   = cnt_inc >= {1'b0, tot_in};
      byte_cnt_in = push_exec ? '0 : cnt_inc[BUF_AW-1:0];
   end

   assign total = {exp_ff, 4'b0000};

   // block geometry, right and bottom clamped to the map
   assign blk_ctrl   = grp_ff[0][2:0];
   assign blk_pc     = grp_ff[1];
   assign blk_xl     = grp_ff[2][4:0];
   assign blk_yt     = grp_ff[3][4:0];
   assign blk_xr_raw = grp_ff[4][4:0];
   assign blk_yb_raw = grp_ff[5][4:0];
   assign blk_xr     = (blk_xr_raw > COL_LAST) ? COL_LAST : blk_xr_raw;
   assign blk_yb     = (blk_yb_raw > ROW_LAST) ? ROW_LAST : blk_yb_raw;
   assign in_rect    = (x_ff >= blk_xl) && (x_ff <= blk_xr) &&
                       (y_ff >= blk_yt) && (y_ff <= blk_yb);
   assign on_border  = in_rect && ((x_ff == blk_xl) || (x_ff == blk_xr) ||
                                   (y_ff == blk_yt) || (y_ff == blk_yb));

   assign div_ctl      = hdr_ff[0];
   assign div_line_raw = hdr_ff[1][4:0];
   always_comb begin
      if (div_ctl[6]) begin
         div_line = (div_line_raw > 5'(ROW_LAST)) ? 5'(ROW_LAST) : div_line_raw;
         div_pos  = 5'(y_ff);
      end else begin
         div_line = (div_line_raw > 5'(COL_LAST)) ? 5'(COL_LAST) : div_line_raw;
         div_pos  = 5'(x_ff);
      end
   end

   assign chr_xl    = hdr_ff[0][4:0];
   assign chr_yt    = hdr_ff[1][4:0];
   assign chr_count = {hdr_ff[3][0], hdr_ff[2]};
   assign chr_bi    = 8'd6 + {1'b0, k_ff[8:2]};
   assign chr_addr  = CELL_W'(y_ff) * CELL_W'(MAP_COLUMNS) + CELL_W'(x_ff);
   always_comb begin
      unique case (k_ff[1:0])
         2'd0:    chr_val = chr_byte_ff[7:6];
         2'd1:    chr_val = chr_byte_ff[5:4];
         2'd2:    chr_val = chr_byte_ff[3:2];
         default: chr_val = chr_byte_ff[1:0];
      endcase
   end

   assign sweep_last = (x_ff == COL_LAST) && (y_ff == ROW_LAST);

   // attribute map write selection
   always_comb begin
      map_we   = 1'b0;
      map_addr = cell_ff;
      map_val  = 2'd0;
      if (cmd.chr_write) begin
         map_we   = 1'b1;
         map_addr = chr_addr;
         map_val  = chr_val;
      end else if (cmd.sweep) begin
         unique case (cmd.sweep_mode)
            SWP_CLEAR: begin
               map_we = 1'b1;
            end
            SWP_BLK: begin
               if (!in_rect) begin
                  map_we  = blk_ctrl[2];
                  map_val = blk_pc[5:4];
               end else if (on_border) begin
                  map_we = (blk_ctrl != 3'd0) && (blk_ctrl != 3'd5);
                  if (blk_ctrl == 3'd1)      map_val = blk_pc[1:0];
                  else if (blk_ctrl == 3'd4) map_val = blk_pc[5:4];
                  else                       map_val = blk_pc[3:2];
               end else begin
                  map_we  = blk_ctrl[0];
                  map_val = blk_pc[1:0];
               end
            end
            SWP_DIV: begin
               map_we = 1'b1;
               if (div_pos < div_line)       map_val = div_ctl[3:2];
               else if (div_pos == div_line) map_val = div_ctl[5:4];
               else                          map_val = div_ctl[1:0];
            end
            default: map_we = 1'b0;
         endcase
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (map_we) attr_mem[map_addr] <= map_val;
      attr_q_ff <= attr_mem[req_read_index];
      if (cmd.accept && req_command == CMD_PUSH) buf_mem[byte_cnt_ff] <= req_data_byte;
      buf_q_ff <= buf_mem[fa_ff[BUF_AW-1:0]];
   end

   assign pal_c = rx_ff[3:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff <= '0;
         exp_ff      <= '0;
         op_ff       <= '0;
         freeze_ff   <= 1'b0;
         fmode_ff    <= '0;
         multi_ff    <= 1'b0;
         players_ff  <= 9'd1;
         fcnt_ff     <= '0;
         fvld_ff     <= 1'b0;
         x_ff        <= '0;
         y_ff        <= '0;
         cell_ff     <= '0;
         for (int i = 0; i < PAL_N; i++) pal_ff[i] <= '0;
      end else begin
         // request transaction
         if (cmd.accept) begin
            pend_op_ff    <= '0;
            pend_value_ff <= '0;
            rd_ok_ff      <= req_read_index < 9'(MAP_CELLS);
            unique case (req_command)
               CMD_PUSH: begin
                  exp_ff         <= exp_in;
                  op_ff          <= op_in;
                  byte_cnt_ff    <= byte_cnt_in;
                  pend_status_ff <= push_exec ? ST_EXECUTED : ST_STORED;
                  if (push_exec) pend_op_ff <= op_in;
               end
               CMD_READ_ATTR: pend_status_ff <= ST_READBACK;
               CMD_READ_PAL: begin
                  pend_status_ff <= ST_READBACK;
                  if (req_read_index < 9'(PAL_N))
                     pend_value_ff <= pal_ff[req_read_index[3:0]];
               end
               default: pend_status_ff <= ST_STORED;
            endcase
         end
         if (cmd.rd_capture && rd_ok_ff) pend_value_ff <= {13'd0, attr_q_ff};

         // packet buffer fetch
         if (cmd.fetch_start) begin
            src_ff  <= cmd.fetch_src;
            rx_ff   <= '0;
            fvld_ff <= 1'b0;
            unique case (cmd.fetch_src)
               SRC_HDR: begin fa_ff <= 8'd1;   fcnt_ff <= 4'd14; end
               SRC_GRP: begin fa_ff <= b_ff;   fcnt_ff <= 4'd6;  end
               default: begin fa_ff <= chr_bi; fcnt_ff <= 4'd1;  end
            endcase
         end else if (fcnt_ff != '0) begin
            fa_ff   <= fa_ff + 8'd1;
            fcnt_ff <= fcnt_ff - 4'd1;
            fvld_ff <= 1'b1;
         end else begin
            fvld_ff <= 1'b0;
         end
         if (fvld_ff) begin
            rx_ff <= rx_ff + 4'd1;
            unique case (src_ff)
               SRC_HDR: begin
                  if (rx_ff < 4'd5) hdr_ff[rx_ff[2:0]] <= buf_q_ff;
                  // palette commands: even bytes complete a colour
                  if (op_ff[4:2] == 3'd0) begin
                     if (!rx_ff[0]) begin
                        low_ff <= buf_q_ff;
                     end else if (pal_c == 3'd0) begin
                        for (int i = 0; i < PAL_N; i += 4)
                           pal_ff[i] <= {buf_q_ff[6:0], low_ff};
                     end else begin
                        pal_ff[PAL_TARGETS[op_ff[1:0]][pal_c - 3'd1]] <=
                           {buf_q_ff[6:0], low_ff};
                     end
                  end
               end
               SRC_GRP: grp_ff[rx_ff[2:0]] <= buf_q_ff;
               default: chr_byte_ff <= buf_q_ff;
            endcase
         end

         if (cmd.dispatch) begin
            g_ff <= '0;
            b_ff <= 8'd2;
            k_ff <= '0;
            if (op_ff == OP_ATTR_CHR) begin
               x_ff       <= chr_xl;
               y_ff       <= chr_yt;
               chr_end_ff <= (chr_xl > COL_LAST) || (chr_yt > ROW_LAST);
            end else begin
               x_ff    <= '0;
               y_ff    <= '0;
               cell_ff <= '0;
            end
            if (op_ff == OP_MLT_REQ) begin
               multi_ff   <= hdr_ff[0][0];
               players_ff <= {1'b0, hdr_ff[0]} + 9'd1;
            end
            if (op_ff == OP_MASK_EN) begin
               freeze_ff <= (hdr_ff[0] != 8'd0) && (hdr_ff[0] < 8'h04);
               fmode_ff  <= hdr_ff[0];
            end
         end

         // raster sweep over the map
         if (cmd.sweep) begin
            if (sweep_last) begin
               x_ff    <= '0;
               y_ff    <= '0;
               cell_ff <= '0;
               if (cmd.sweep_mode == SWP_BLK) begin
                  g_ff <= g_ff + 5'd1;
                  b_ff <= b_ff + 8'd6;
               end
            end else begin
               cell_ff <= cell_ff + CELL_W'(1);
               if (x_ff == COL_LAST) begin
                  x_ff <= '0;
                  y_ff <= y_ff + Y_W'(1);
               end else begin
                  x_ff <= x_ff + X_W'(1);
               end
            end
         end

         // character attribute walk; wrap restarts at the start column/row
         if (cmd.chr_write) begin
            k_ff <= k_ff + 9'd1;
            if (hdr_ff[4][0]) begin
               if (y_ff == ROW_LAST) begin
                  y_ff <= chr_yt;
                  if (x_ff == COL_LAST) chr_end_ff <= 1'b1;
                  else                  x_ff <= x_ff + X_W'(1);
               end else begin
                  y_ff <= y_ff + Y_W'(1);
               end
            end else begin
               if (x_ff == COL_LAST) begin
                  x_ff <= chr_xl;
                  if (y_ff == ROW_LAST) chr_end_ff <= 1'b1;
                  else                  y_ff <= y_ff + Y_W'(1);
               end else begin
                  x_ff <= x_ff + X_W'(1);
               end
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status          <= pend_status_ff;
         rsp_read_value      <= pend_value_ff;
         rsp_executed_opcode <= pend_op_ff;
         rsp_freeze_active   <= freeze_ff;
         rsp_freeze_mode     <= fmode_ff;
         rsp_multiplayer_on  <= multi_ff;
         rsp_player_count    <= players_ff;
      end
   end

   always_comb begin
      stat.push_exec  = push_exec;
      stat.fetch_done = (fcnt_ff == '0) && !fvld_ff;
      stat.sweep_last = sweep_last;
      stat.is_blk     = op_ff == OP_ATTR_BLK;
      stat.is_div     = op_ff == OP_ATTR_DIV;
      stat.is_chr     = op_ff == OP_ATTR_CHR;
      stat.grp_end    = (g_ff >= hdr_ff[0][4:0]) ||
                        (({1'b0, b_ff} + 9'd5) >= {2'b00, total});
      stat.blk_bad    = (blk_xl > COL_LAST) || (blk_yt > ROW_LAST) ||
                        (blk_xl > blk_xr) || (blk_yt > blk_yb);
      stat.chr_stop   = chr_end_ff || (k_ff >= chr_count) ||
                        (chr_bi >= {1'b0, total});
   end

endmodule

[rtl/sgb_cpp_ctrl.sv]
// sgb_cpp_ctrl: sequencing state machine and channel handshakes
// uses sgb_cpp_pkg; drives the datapath through sgb_cpp_cmd_type
`timescale 1ns / 1ps
module sgb_cpp_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [1:0]                    req_command,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  sgb_cpp_pkg::sgb_cpp_stat_type stat,
   output sgb_cpp_pkg::sgb_cpp_cmd_type  cmd
);
   import sgb_cpp_pkg::*;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_RD       = 4'd2;
   localparam logic [3:0] S_FETCH_H  = 4'd3;
   localparam logic [3:0] S_DISPATCH = 4'd4;
   localparam logic [3:0] S_BLK_NEXT = 4'd5;
   localparam logic [3:0] S_FETCH_G  = 4'd6;
   localparam logic [3:0] S_SWEEP_B  = 4'd7;
   localparam logic [3:0] S_SWEEP_D  = 4'd8;
   localparam logic [3:0] S_CHR_CHK  = 4'd9;
   localparam logic [3:0] S_FETCH_C  = 4'd10;
   localparam logic [3:0] S_CHR_WR   = 4'd11;
   localparam logic [3:0] S_FINISH   = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.sweep      = 1'b1;
            cmd.sweep_mode = SWP_CLEAR;
            if (stat.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_command == CMD_PUSH) begin
                  if (stat.push_exec) begin
                     cmd.fetch_start = 1'b1;
                     cmd.fetch_src   = SRC_HDR;
                     state_in        = S_FETCH_H;
                  end else begin
                     state_in = S_FINISH;
                  end
               end else if (req_command == CMD_READ_ATTR) begin
                  state_in = S_RD;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_RD: begin
            cmd.rd_capture = 1'b1;
            state_in       = S_FINISH;
         end
         S_FETCH_H: begin
            if (stat.fetch_done) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            cmd.dispatch = 1'b1;
            priority if (stat.is_blk) state_in = S_BLK_NEXT;
            else if (stat.is_div)     state_in = S_SWEEP_D;
            else if (stat.is_chr)     state_in = S_CHR_CHK;
            else                      state_in = S_FINISH;
         end
         S_BLK_NEXT: begin
            if (stat.grp_end) begin
               state_in = S_FINISH;
            end else begin
               cmd.fetch_start = 1'b1;
               cmd.fetch_src   = SRC_GRP;
               state_in        = S_FETCH_G;
            end
         end
         S_FETCH_G: begin
            if (stat.fetch_done) state_in = stat.blk_bad ? S_FINISH : S_SWEEP_B;
         end
         S_SWEEP_B: begin
            cmd.sweep      = 1'b1;
            cmd.sweep_mode = SWP_BLK;
            if (stat.sweep_last) state_in = S_BLK_NEXT;
         end
         S_SWEEP_D: begin
            cmd.sweep      = 1'b1;
            cmd.sweep_mode = SWP_DIV;
            if (stat.sweep_last) state_in = S_FINISH;
         end
         S_CHR_CHK: begin
            if (stat.chr_stop) begin
               state_in = S_FINISH;
            end else begin
               cmd.fetch_start = 1'b1;
               cmd.fetch_src   = SRC_CHR;
               state_in        = S_FETCH_C;
            end
         end
         S_FETCH_C: begin
            if (stat.fetch_done) state_in = S_CHR_WR;
         end
         S_CHR_WR: begin
            cmd.chr_write = 1'b1;
            state_in      = S_CHR_CHK;
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/sgb_command_packet_processor_unit.sv]
// Command packet processor: one transaction on req at a time, one result on rsp per
// transaction. After reset a clearing pass writes the 360-cell attribute map to zero, one
// cell a cycle, before the first transaction is taken. A completed command first fetches
// 14 header bytes from the packet buffer, which covers the palette loads, MLT_REQ and
// MASK_EN. ATTR_DIV then sweeps the map, one cell a cycle; ATTR_BLK fetches each group
// and sweeps the map for each group that it applies; ATTR_CHR fetches the byte of each
// attribute through the single buffer read port before it writes that attribute. A
// finished result waits in the output register until taken.
// Depends on sgb_cpp_pkg, sgb_cpp_req_if, sgb_cpp_rsp_if, sgb_cpp_ctrl, sgb_cpp_datapath.
`timescale 1ns / 1ps
module sgb_command_packet_processor_unit (
   input logic         clock,
   input logic         reset,
   sgb_cpp_req_if.sink req_channel,
   sgb_cpp_rsp_if.source rsp_channel
);
   import sgb_cpp_pkg::*;

   sgb_cpp_cmd_type  cmd;
   sgb_cpp_stat_type stat;

   sgb_cpp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_channel.valid),
      .req_command (req_channel.command),
      .req_ready   (req_channel.ready),
      .rsp_valid   (rsp_channel.valid),
      .rsp_ready   (rsp_channel.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   sgb_cpp_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_command         (req_channel.command),
      .req_data_byte       (req_channel.data_byte),
      .req_read_index      (req_channel.read_index),
      .rsp_status          (rsp_channel.status),
      .rsp_read_value      (rsp_channel.read_value),
      .rsp_executed_opcode (rsp_channel.executed_opcode),
      .rsp_freeze_active   (rsp_channel.freeze_active),
      .rsp_freeze_mode     (rsp_channel.freeze_mode),
      .rsp_multiplayer_on  (rsp_channel.multiplayer_on),
      .rsp_player_count    (rsp_channel.player_count)
   );

endmodule

[tb/tb_sgb_command_packet_processor_unit.sv]
// tb_sgb_command_packet_processor_unit: self-checking bench for the command packet processor;
// a behavioural attribute/palette predictor scores every result on the rsp channel
// depends on sgb_cpp_pkg, sgb_cpp_req_if, sgb_cpp_rsp_if and the unit itself
`timescale 1ns / 1ps
module tb_sgb_command_packet_processor_unit;
   import sgb_cpp_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [4:0] OP_PAL01 = 5'h00;
   localparam logic [4:0] OP_PAL23 = 5'h01;
   localparam logic [4:0] OP_PAL03 = 5'h02;
   localparam logic [4:0] OP_PAL12 = 5'h03;
   localparam int RANDOM_ITEMS = 650;
   localparam int HOLD_CYCLES  = 900;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic [8:0] read_index;
   } cmd_item_t;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] read_value;
      logic [4:0]  executed_opcode;
      logic        freeze_active;
      logic [7:0]  freeze_mode;
      logic        multiplayer_on;
      logic [8:0]  player_count;
   } sgb_result_t;

   typedef struct packed {
      cmd_item_t   item;
      logic        typed;
      logic [1:0]  status;
      logic [14:0] read_value;
   } table_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sgb_cpp_req_if req_bus ();
   sgb_cpp_rsp_if rsp_bus ();

   sgb_command_packet_processor_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_channel(req_bus),
      .rsp_channel(rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow of the unit's state
   logic [7:0]  pkt_bytes   [BUF_DEPTH];
   logic [1:0]  attr_cells  [MAP_CELLS];
   logic [14:0] colours     [PAL_N];
   int          byte_fill;
   int          packets_due;
   logic [4:0]  cur_op;
   logic        freeze_on;
   logic [7:0]  freeze_byte;
   logic        multi_on;
   logic [8:0]  players_now;

   sgb_result_t expected_results [$];
   cmd_item_t   stim_q [$];
   int          error_count = 0;
   int          results_seen = 0;
   bit          burst_mode = 1'b0;

   function automatic void put_cell(int x, int y, logic [1:0] p);
      if (x >= 0 && x < MAP_COLUMNS && y >= 0 && y < MAP_ROWS)
         attr_cells[y * MAP_COLUMNS + x] = p;
   endfunction

   function automatic logic [14:0] colour_from(int i);
      return {pkt_bytes[i + 1][6:0], pkt_bytes[i]};
   endfunction

   function automatic void paint_block(int total);
      int groups, b, ctrl, pc, xl, yt, xr, yb;
      logic [1:0] p;
      groups = pkt_bytes[1] & 8'h1f;
      for (int g = 0; g < groups; g++) begin
         b = 2 + 6 * g;
         if (b + 5 >= total) break;
         ctrl = pkt_bytes[b] & 8'h07;
         pc   = pkt_bytes[b + 1] & 8'h3f;
         xl   = pkt_bytes[b + 2] & 8'h1f;
         yt   = pkt_bytes[b + 3] & 8'h1f;
         xr   = pkt_bytes[b + 4] & 8'h1f;
         yb   = pkt_bytes[b + 5] & 8'h1f;
         if (xl > MAP_COLUMNS - 1 || yt > MAP_ROWS - 1) break;
         if (xr > MAP_COLUMNS - 1) xr = MAP_COLUMNS - 1;
         if (yb > MAP_ROWS - 1) yb = MAP_ROWS - 1;
         if (xl > xr || yt > yb) break;
         if (ctrl & 4) begin
            p = 2'((pc >> 4) & 3);
            for (int y = 0; y < MAP_ROWS; y++)
               for (int x = 0; x < MAP_COLUMNS; x++)
                  if (x < xl || x > xr || y < yt || y > yb) put_cell(x, y, p);
         end
         if (ctrl & 1) begin
            p = 2'(pc & 3);
            for (int y = yt + 1; y < yb; y++)
               for (int x = xl + 1; x < xr; x++) put_cell(x, y, p);
         end
         if (ctrl != 0 && ctrl != 5) begin
            if (ctrl == 1) p = 2'(pc & 3);
            else if (ctrl == 4) p = 2'((pc >> 4) & 3);
            else p = 2'((pc >> 2) & 3);
            for (int y = yt; y <= yb; y++) begin
               put_cell(xl, y, p);
               put_cell(xr, y, p);
            end
            for (int x = xl; x <= xr; x++) begin
               put_cell(x, yt, p);
               put_cell(x, yb, p);
            end
         end
      end
   endfunction

   function automatic void paint_division();
      logic [7:0] ctl;
      int line, pos;
      logic [1:0] p;
      ctl  = pkt_bytes[1];
      line = pkt_bytes[2] & 8'h1f;
      if (ctl[6]) begin
         if (line > MAP_ROWS - 1) line = MAP_ROWS - 1;
      end else begin
         if (line > MAP_COLUMNS - 1) line = MAP_COLUMNS - 1;
      end
      for (int y = 0; y < MAP_ROWS; y++)
         for (int x = 0; x < MAP_COLUMNS; x++) begin
            pos = ctl[6] ? y : x;
            p = (pos < line) ? ctl[3:2] : ((pos == line) ? ctl[5:4] : ctl[1:0]);
            put_cell(x, y, p);
         end
   endfunction

   function automatic void paint_chars(int total);
      int xl, yt, count, x, y, bi, sh;
      logic vertical;
      xl = pkt_bytes[1] & 8'h1f;
      yt = pkt_bytes[2] & 8'h1f;
      count = {pkt_bytes[4][0], pkt_bytes[3]};
      vertical = pkt_bytes[5][0];
      x = xl;
      y = yt;
      if (xl > MAP_COLUMNS - 1 || yt > MAP_ROWS - 1) return;
      for (int k = 0; k < count; k++) begin
         bi = 6 + (k >> 2);
         sh = 6 - 2 * (k & 3);
         if (bi >= total) break;
         put_cell(x, y, 2'((pkt_bytes[bi] >> sh) & 3));
         if (vertical) begin
            y++;
            if (y >= MAP_ROWS) begin
               y = yt;
               x++;
               if (x >= MAP_COLUMNS) break;
            end
         end else begin
            x++;
            if (x >= MAP_COLUMNS) begin
               x = xl;
               y++;
               if (y >= MAP_ROWS) break;
            end
         end
      end
   endfunction

   function automatic void run_command(int total);
      case (cur_op)
         OP_PAL01, OP_PAL23, OP_PAL03, OP_PAL12: begin
            colours[0]  = colour_from(1);
            colours[4]  = colours[0];
            colours[8]  = colours[0];
            colours[12] = colours[0];
            for (int k = 0; k < 6; k++)
               colours[PAL_TARGETS[cur_op[1:0]][k]] = colour_from(3 + 2 * k);
         end
         OP_ATTR_BLK: paint_block(total);
         OP_ATTR_DIV: paint_division();
         OP_ATTR_CHR: paint_chars(total);
         OP_MLT_REQ: begin
            multi_on    = pkt_bytes[1][0];
            players_now = {1'b0, pkt_bytes[1]} + 9'd1;
         end
         OP_MASK_EN: begin
            freeze_on   = (pkt_bytes[1] != 0 && pkt_bytes[1] < 8'h04);
            freeze_byte = pkt_bytes[1];
         end
         default: ;
      endcase
   endfunction

   function automatic sgb_result_t predict_result(cmd_item_t it);
      sgb_result_t r;
      int total;
      r = '0;
      case (it.command)
         CMD_PUSH: begin
            if (byte_fill == 0) begin
               packets_due = it.data_byte[2:0];
               if (packets_due == 0) packets_due = 1;
               cur_op = it.data_byte[7:3];
            end
            total = packets_due * PACKET_BYTES;
            if (byte_fill < BUF_DEPTH) pkt_bytes[byte_fill] = it.data_byte;
            byte_fill++;
            r.status = ST_STORED;
            if (byte_fill >= total) begin
               run_command(total);
               r.status = ST_EXECUTED;
               r.executed_opcode = cur_op;
               byte_fill = 0;
            end
         end
         CMD_READ_ATTR: begin
            r.status = ST_READBACK;
            if (it.read_index < MAP_CELLS)
               r.read_value = {13'd0, attr_cells[it.read_index]};
         end
         CMD_READ_PAL: begin
            r.status = ST_READBACK;
            if (it.read_index < PAL_N) r.read_value = colours[it.read_index[3:0]];
         end
         default: r.status = ST_STORED;
      endcase
      r.freeze_active  = freeze_on;
      r.freeze_mode    = freeze_byte;
      r.multiplayer_on = multi_on;
      r.player_count   = players_now;
      return r;
   endfunction

   function automatic cmd_item_t push_byte(logic [7:0] b);
      cmd_item_t it;
      it.command    = CMD_PUSH;
      it.data_byte  = b;
      it.read_index = 9'($urandom_range(0, 511));
      return it;
   endfunction

   function automatic cmd_item_t random_read();
      cmd_item_t it;
      int pick;
      pick = $urandom_range(0, 9);
      it.data_byte = 8'($urandom);
      if (pick < 5) begin
         it.command = CMD_READ_ATTR;
         it.read_index = (pick == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(0, 359));
      end else if (pick < 9) begin
         it.command = CMD_READ_PAL;
         it.read_index = (pick == 5) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(0, 15));
      end else begin
         it.command = CMD_UNUSED;
         it.read_index = 9'($urandom);
      end
      return it;
   endfunction

   // one whole command, mostly well-formed with random content
   function automatic void queue_command(int serial);
      logic [4:0] op;
      logic [2:0] cnt;
      logic [7:0] body [BUF_DEPTH];
      int total, pick, ng;
      pick = $urandom_range(0, 99);
      case (serial < 10 ? serial : $urandom_range(0, 11))
         0: op = OP_PAL01;
         1: op = OP_PAL23;
         2: op = OP_PAL03;
         3: op = OP_PAL12;
         4, 10: op = OP_ATTR_BLK;
         5, 11: op = OP_ATTR_DIV;
         6: op = OP_ATTR_CHR;
         7: op = OP_MLT_REQ;
         8: op = OP_MASK_EN;
         default: op = 5'($urandom);
      endcase
      if (pick < 70) cnt = 3'($urandom_range(0, 1));
      else if (pick < 95) cnt = 3'($urandom_range(2, 3));
      else cnt = 3'd7;
      total = (cnt == 0 ? 1 : cnt) * PACKET_BYTES;
      for (int i = 0; i < BUF_DEPTH; i++) body[i] = 8'($urandom);
      body[0] = {op, cnt};
      if (op == OP_ATTR_BLK && pick < 85) begin
         ng = $urandom_range(1, 4);
         body[1] = 8'(ng) | (8'($urandom) & 8'he0);
         for (int g = 0; g < ng; g++) begin
            body[4 + 6 * g] = 8'($urandom_range(0, 21));
            body[5 + 6 * g] = 8'($urandom_range(0, 19));
            body[6 + 6 * g] = 8'($urandom_range(0, 31));
            body[7 + 6 * g] = 8'($urandom_range(0, 31));
         end
      end else if (op == OP_ATTR_CHR && pick < 85) begin
         body[1] = 8'($urandom_range(0, 21));
         body[2] = 8'($urandom_range(0, 19));
      end else if (op == OP_MASK_EN && pick < 60) begin
         body[1] = 8'($urandom_range(0, 4));
      end
      for (int i = 0; i < total; i++) begin
         stim_q.push_back(push_byte(body[i]));
         if ($urandom_range(0, 19) == 0) stim_q.push_back(random_read());
      end
      // follow each command with three random reads
      for (int i = 0; i < 3; i++) stim_q.push_back(random_read());
   endfunction

   // receiver: random stalls, one long hold-off
   initial begin
      sgb_result_t got, want;
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = burst_mode ? 0 : $urandom_range(0, 4);
         if (results_seen == 150) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1));
         got = '{rsp_bus.status, rsp_bus.read_value, rsp_bus.executed_opcode,
                 rsp_bus.freeze_active, rsp_bus.freeze_mode, rsp_bus.multiplayer_on,
                 rsp_bus.player_count};
         results_seen++;
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transaction, expected none, got %h", $time, got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               error_count++;
               $display("%0t: mismatch expected st=%0d val=%h op=%h frz=%b/%h mlt=%b pl=%0d got st=%0d val=%h op=%h frz=%b/%h mlt=%b pl=%0d",
                  $time, want.status, want.read_value, want.executed_opcode,
                  want.freeze_active, want.freeze_mode, want.multiplayer_on,
                  want.player_count, got.status, got.read_value, got.executed_opcode,
                  got.freeze_active, got.freeze_mode, got.multiplayer_on,
                  got.player_count);
            end
         end
      end
   end

   // sender
   initial begin
      table_row_t dir_rows [$];
      cmd_item_t it;
      sgb_result_t want;
      int gap, sent, serial;
      dir_rows = '{
         '{'{CMD_READ_ATTR, 8'h00, 9'd0},   1'b1, ST_READBACK, 15'd0},
         '{'{CMD_READ_ATTR, 8'hff, 9'd359}, 1'b1, ST_READBACK, 15'd0},
         '{'{CMD_READ_ATTR, 8'h00, 9'd360}, 1'b1, ST_READBACK, 15'd0},
         '{'{CMD_READ_ATTR, 8'hff, 9'd511}, 1'b1, ST_READBACK, 15'd0},
         '{'{CMD_READ_PAL, 8'h00, 9'd0},    1'b1, ST_READBACK, 15'd0},
         '{'{CMD_READ_PAL, 8'h00, 9'd15},   1'b1, ST_READBACK, 15'd0},
         '{'{CMD_READ_PAL, 8'hff, 9'd16},   1'b1, ST_READBACK, 15'd0},
         '{'{CMD_READ_PAL, 8'h55, 9'd511},  1'b1, ST_READBACK, 15'd0},
         '{'{CMD_UNUSED, 8'hff, 9'd511},    1'b1, ST_STORED,   15'd0},
         '{'{CMD_UNUSED, 8'h00, 9'd0},      1'b1, ST_STORED,   15'd0},
         '{'{CMD_PUSH, {OP_MASK_EN, 3'd0}, 9'd0}, 1'b1, ST_STORED, 15'd0},
         '{'{CMD_PUSH, 8'hff, 9'd511},      1'b0, ST_STORED,   15'd0},
         '{'{CMD_READ_ATTR, 8'h00, 9'd21},  1'b0, ST_READBACK, 15'd0}
      };
      for (int i = 0; i < BUF_DEPTH; i++) pkt_bytes[i] = 8'h00;
      for (int i = 0; i < MAP_CELLS; i++) attr_cells[i] = 2'd0;
      for (int i = 0; i < PAL_N; i++) colours[i] = 15'd0;
      byte_fill = 0; packets_due = 0; cur_op = '0;
      freeze_on = 1'b0; freeze_byte = '0; multi_on = 1'b0; players_now = 9'd1;
      foreach (dir_rows[i]) stim_q.push_back(dir_rows[i].item);
      // finish the mask enable command opened by the table (mode 0xff, freeze off)
      for (int i = 0; i < 14; i++) stim_q.push_back(push_byte(8'($urandom)));
      serial = 0;
      while (stim_q.size() < RANDOM_ITEMS + 27) begin
         queue_command(serial);
         serial++;
      end

      req_bus.valid <= 1'b0;
      req_bus.command <= CMD_PUSH;
      req_bus.data_byte <= 8'h00;
      req_bus.read_index <= 9'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      sent = 0;
      while (stim_q.size() > 0) begin
         it = stim_q.pop_front();
         if (sent % 80 == 40) burst_mode = ~burst_mode;
         gap = burst_mode ? 0 : $urandom_range(0, 4);
         if (sent == 300) begin
            // let the unit drain completely
            req_bus.valid <= 1'b0;
            while (expected_results.size() > 0) @(posedge clock);
            gap = 0;
         end else if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_bus.valid <= 1'b1;
         req_bus.command <= it.command;
         req_bus.data_byte <= it.data_byte;
         req_bus.read_index <= it.read_index;
         do @(posedge clock); while (!(req_bus.ready === 1'b1));
         want = predict_result(it);
         if (sent < dir_rows.size() && dir_rows[sent].typed) begin
            want = '{dir_rows[sent].status, dir_rows[sent].read_value, 5'd0,
                     1'b0, 8'h00, 1'b0, 9'd1};
         end
         expected_results.push_back(want);
         sent++;
      end
      req_bus.valid <= 1'b0;
      while (expected_results.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("[sgb_command_packet_processor_unit] OK");
      else $display("[sgb_command_packet_processor_unit] ERROR");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("[sgb_command_packet_processor_unit] ERROR");
      $finish;
   end

endmodule
